// File: src/itc_pkg.sv
// Package for the three-channel interval timer.
// Holds item modes, port and access-order constants and the sequencer state type; no dependencies.
`default_nettype none
package itc_pkg;
  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModeRead  = 2'd1;
  localparam logic [1:0] ModeTick  = 2'd2;
  localparam logic [15:0] CtrlPort = 16'h0043;
  localparam logic [15:0] BasePort = 16'h0040;
  localparam logic [1:0] OrderLatch = 2'd0;
  localparam logic [1:0] OrderLow   = 2'd1;
  localparam logic [1:0] OrderHigh  = 2'd2;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StPrep = 5'b00010,
    StDiv  = 5'b00100,
    StFin  = 5'b01000,
    StOut  = 5'b10000
  } state_e;
endpackage
`default_nettype wire

// File: src/interval_timer_three_channel.sv
// Top level of the three-channel interval timer: port decode, channel state
// and a shared restoring divider for tick items. Uses itc_pkg.
//
// Channel | Direction | Fields
// s_axis  | in        | tdata: mode[1:0], port_address[17:2], write_data[25:18],
//         |           |        tick_count[57:26]
// m_axis  | out       | tdata: read_data[7:0], channel0_fired[8], channel2_flag[9]
//
// Writes and reads pass through the prepare state before output. A tick item
// handles the channels one after another; each channel needs a prepare state,
// and 32 divider steps and a finish state when it reaches terminal count.
// Input ready is low until the result has been taken.
// Reset is asynchronous; it clears all channel state and sets each access order to low-then-high.
`default_nettype none
module interval_timer_three_channel #(
  parameter int NUM_CHANNELS = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // mode, port_address, write_data, tick_count
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // read_data, channel0_fired, channel2_flag
);
  localparam int NC = (NUM_CHANNELS < 1) ? 1 : NUM_CHANNELS;
  localparam int CW = (NC > 1) ? $clog2(NC) : 1;
  // Only the first three channels are ever advanced.
  localparam int NA = (NC > 3) ? 3 : NC;

  itc_pkg::state_e st_q, st_d;
  logic [15:0] rl_q [NC];
  logic [15:0] cnt_q [NC];
  logic [15:0] lat_q [NC];
  logic [NC-1:0] held_q, whn_q, rhn_q, fired_q;
  logic [1:0]  ord_q [NC];

  logic [1:0]  mode_q;
  logic [15:0] port_q;
  logic [7:0]  wd_q;
  logic [31:0] ticks_q;
  logic [CW-1:0] ch_q;
  logic [5:0]  step_q;
  logic [31:0] num_q;   // dividend shifting out
  logic [16:0] rem_q;
  logic [16:0] div_q;   // reload as 1..65536
  logic [7:0]  rd_q;
  logic        f0_q;

  assign s_axis_tready = (st_q == itc_pkg::StIdle);
  assign m_axis_tvalid = (st_q == itc_pkg::StOut);

  logic f2;
  always_comb begin
    f2 = 1'b0;
    if (NC > 2) f2 = fired_q[NC-1];
  end
  assign m_axis_tdata = {6'd0, f2, f0_q, rd_q};

  // Decode of the held item.
  logic [15:0] off;
  logic        port_ok;
  logic [CW-1:0] pch;
  logic [1:0]  sel, rw;
  logic        sel_ok;
  logic [CW-1:0] sch;
  assign off = port_q - itc_pkg::BasePort;
  assign port_ok = (port_q >= itc_pkg::BasePort) && (port_q != itc_pkg::CtrlPort)
                   && (off < 16'(NC)) && (off < 16'd3);
  assign pch = off[CW-1:0];
  assign sel = wd_q[7:6];
  assign rw  = wd_q[5:4];
  assign sel_ok = (sel != 2'd3) && ({30'd0, sel} < NC);
  assign sch = sel[CW-1:0];

  // Tick preparation for the current channel.
  logic [16:0] rl_x, cnt_x;
  logic [31:0] diff;
  assign rl_x  = (rl_q[ch_q] == 16'd0) ? 17'h10000 : {1'b0, rl_q[ch_q]};
  assign cnt_x = (cnt_q[ch_q] == 16'd0) ? rl_x : {1'b0, cnt_q[ch_q]};
  assign diff  = ticks_q - {15'd0, cnt_x};

  logic [17:0] trial;
  assign trial = {rem_q, num_q[31]} - {1'b0, div_q};

  always_comb begin
    st_d = st_q;
    case (st_q)
      itc_pkg::StIdle: if (s_axis_tvalid) st_d = itc_pkg::StPrep;
      itc_pkg::StPrep: begin
        if (mode_q != itc_pkg::ModeTick) st_d = itc_pkg::StOut;
        else if (ticks_q >= {15'd0, cnt_x}) st_d = itc_pkg::StDiv;
        else if (ch_q == CW'(NA - 1)) st_d = itc_pkg::StOut;
      end
      itc_pkg::StDiv: if (step_q == 6'd31) st_d = itc_pkg::StFin;
      itc_pkg::StFin:
        if (ch_q == CW'(NA - 1)) st_d = itc_pkg::StOut;
        else st_d = itc_pkg::StPrep;
      itc_pkg::StOut: if (m_axis_tready) st_d = itc_pkg::StIdle;
      default: st_d = itc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= itc_pkg::StIdle;
      for (int i = 0; i < NC; i++) begin
        rl_q[i] <= '0; cnt_q[i] <= '0; lat_q[i] <= '0; ord_q[i] <= 2'd3;
      end
      held_q <= '0; whn_q <= '0; rhn_q <= '0; fired_q <= '0;
      ch_q <= '0; step_q <= '0; f0_q <= 1'b0; rd_q <= '0; mode_q <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        itc_pkg::StIdle: if (s_axis_tvalid) begin
          mode_q  <= s_axis_tdata[1:0];
          port_q  <= s_axis_tdata[17:2];
          wd_q    <= s_axis_tdata[25:18];
          ticks_q <= s_axis_tdata[57:26];
          ch_q <= '0; f0_q <= 1'b0; rd_q <= '0;
        end
        itc_pkg::StPrep: begin
          if (mode_q == itc_pkg::ModeWrite) begin
            if (port_q == itc_pkg::CtrlPort) begin
              if (sel_ok) begin
                if (rw == itc_pkg::OrderLatch) begin
                  lat_q[sch] <= (cnt_q[sch] != 16'd0) ? cnt_q[sch] : rl_q[sch];
                  held_q[sch] <= 1'b1;
                end else begin
                  ord_q[sch] <= rw; whn_q[sch] <= 1'b0; held_q[sch] <= 1'b0;
                end
              end
            end else if (port_ok) begin
              if (ord_q[pch] == itc_pkg::OrderLow) begin
                rl_q[pch] <= {rl_q[pch][15:8], wd_q};
                cnt_q[pch] <= {rl_q[pch][15:8], wd_q};
              end else if (ord_q[pch] == itc_pkg::OrderHigh || whn_q[pch]) begin
                rl_q[pch] <= {wd_q, rl_q[pch][7:0]};
                cnt_q[pch] <= {wd_q, rl_q[pch][7:0]};
                whn_q[pch] <= 1'b0;
              end else begin
                rl_q[pch][7:0] <= wd_q;
                whn_q[pch] <= 1'b1;
              end
            end
          end else if (mode_q == itc_pkg::ModeRead) begin
            if (port_q == itc_pkg::CtrlPort) rd_q <= 8'd0;
            else if (!port_ok) rd_q <= 8'hFF;
            else begin
              logic [15:0] v;
              v = held_q[pch] ? lat_q[pch] : cnt_q[pch];
              if (ord_q[pch] == itc_pkg::OrderLow) rd_q <= v[7:0];
              else if (ord_q[pch] == itc_pkg::OrderHigh) rd_q <= v[15:8];
              else if (!rhn_q[pch]) begin
                rd_q <= v[7:0]; rhn_q[pch] <= 1'b1;
              end else begin
                rd_q <= v[15:8]; rhn_q[pch] <= 1'b0; held_q[pch] <= 1'b0;
              end
            end
          end else if (mode_q == itc_pkg::ModeTick) begin
            if (ticks_q >= {15'd0, cnt_x}) begin
              num_q <= diff; rem_q <= '0; div_q <= rl_x; step_q <= '0;
              fired_q[ch_q] <= 1'b1;
              if (ch_q == '0) f0_q <= 1'b1;
            end else begin
              cnt_q[ch_q] <= 16'(cnt_x - ticks_q[16:0]);
              ch_q <= ch_q + CW'(1);
            end
          end
        end
        itc_pkg::StDiv: begin
          if (!trial[17]) rem_q <= trial[16:0];
          else rem_q <= {rem_q[15:0], num_q[31]};
          num_q <= {num_q[30:0], 1'b0};
          step_q <= step_q + 6'd1;
        end
        itc_pkg::StFin: begin
          cnt_q[ch_q] <= 16'(div_q - rem_q);
          ch_q <= ch_q + CW'(1);
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: tb/interval_timer_three_channel_tb.sv
// Self-checking testbench for the three-channel interval timer.
// Drives port writes, port reads and tick items over the input stream and checks
// each result transaction against a behavioural predictor. Depends on itc_pkg and the DUT.
`timescale 1ns / 100ps
`default_nettype none
module interval_timer_three_channel_tb;

  localparam int NumChan = 3;
  localparam logic [1:0] ModeSpare = 2'd3;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] port;
    logic [7:0]  wdata;
    logic [31:0] ticks;
  } timer_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       fired0;
    logic       flag2;
  } timer_result_t;

  typedef struct {
    timer_item_t   item;
    logic          known;
    timer_result_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  interval_timer_three_channel #(.NUM_CHANNELS(NumChan)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state per channel.
  logic [15:0] reload_q [NumChan];
  logic [15:0] count_q  [NumChan];
  logic [15:0] latch_q  [NumChan];
  logic        held_q   [NumChan];
  logic [1:0]  order_q  [NumChan];
  logic        wr_hi_q  [NumChan];
  logic        rd_hi_q  [NumChan];
  logic        fired_q  [NumChan];

  timer_result_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 28;
  int recv_idle_pct = 88;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic timer_result_t predict_timer(input timer_item_t it);
    timer_result_t r;
    int unsigned sel, rw, n;
    logic [15:0] v;
    longint unsigned rl, cnt;
    r = '0;
    if (it.mode == itc_pkg::ModeWrite) begin
      if (it.port == itc_pkg::CtrlPort) begin
        sel = it.wdata[7:6];
        rw = it.wdata[5:4];
        if (sel < NumChan) begin
          if (rw == itc_pkg::OrderLatch) begin
            latch_q[sel] = (count_q[sel] != 0) ? count_q[sel] : reload_q[sel];
            held_q[sel] = 1'b1;
          end else begin
            order_q[sel] = rw[1:0];
            wr_hi_q[sel] = 1'b0;
            held_q[sel] = 1'b0;
          end
        end
      end else if (it.port >= itc_pkg::BasePort && it.port - itc_pkg::BasePort < NumChan) begin
        n = it.port - itc_pkg::BasePort;
        if (order_q[n] == itc_pkg::OrderLow) begin
          reload_q[n][7:0] = it.wdata;
          count_q[n] = reload_q[n];
        end else if (order_q[n] == itc_pkg::OrderHigh) begin
          reload_q[n][15:8] = it.wdata;
          count_q[n] = reload_q[n];
        end else if (!wr_hi_q[n]) begin
          reload_q[n][7:0] = it.wdata;
          wr_hi_q[n] = 1'b1;
        end else begin
          reload_q[n][15:8] = it.wdata;
          wr_hi_q[n] = 1'b0;
          count_q[n] = reload_q[n];
        end
      end
    end else if (it.mode == itc_pkg::ModeRead) begin
      if (it.port == itc_pkg::CtrlPort) r.rdata = 8'h00;
      else if (it.port < itc_pkg::BasePort || it.port - itc_pkg::BasePort >= NumChan)
        r.rdata = 8'hFF;
      else begin
        n = it.port - itc_pkg::BasePort;
        v = held_q[n] ? latch_q[n] : count_q[n];
        if (order_q[n] == itc_pkg::OrderLow) r.rdata = v[7:0];
        else if (order_q[n] == itc_pkg::OrderHigh) r.rdata = v[15:8];
        else if (!rd_hi_q[n]) begin
          rd_hi_q[n] = 1'b1;
          r.rdata = v[7:0];
        end else begin
          rd_hi_q[n] = 1'b0;
          held_q[n] = 1'b0;
          r.rdata = v[15:8];
        end
      end
    end else if (it.mode == itc_pkg::ModeTick) begin
      for (int i = 0; i < NumChan; i++) begin
        rl = (reload_q[i] != 0) ? reload_q[i] : 64'h10000;
        cnt = (count_q[i] != 0) ? count_q[i] : rl;
        if (it.ticks >= cnt) begin
          cnt = rl - ((it.ticks - cnt) % rl);
          fired_q[i] = 1'b1;
          if (i == 0) r.fired0 = 1'b1;
        end else cnt = cnt - it.ticks;
        count_q[i] = cnt[15:0];
      end
    end
    r.flag2 = (NumChan > 2) ? fired_q[2] : 1'b0;
    return r;
  endfunction

  // Entered at a falling edge; leaves valid high after the handshake so that
  // back-to-back transactions need only one assignment per falling edge.
  task automatic send_item(input timer_item_t it, input logic known, input timer_result_t res);
    timer_result_t p;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    p = predict_timer(it);
    if (known && p != res)
      report_mismatch($sformatf("table row disagrees with predictor: %h vs %h", res, p));
    expected_q.push_back(known ? res : p);
    s_axis_tdata <= {6'b0, it.ticks, it.wdata, it.port, it.mode};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic timer_item_t mk(input logic [1:0] m, input logic [15:0] p,
                                     input logic [7:0] d, input logic [31:0] t);
    timer_item_t it;
    it.mode = m; it.port = p; it.wdata = d; it.ticks = t;
    return it;
  endfunction

  function automatic timer_item_t random_item();
    timer_item_t it;
    int unsigned k;
    it.ticks = $urandom_range(0, 200000);
    it.wdata = 8'($urandom_range(0, 255));
    it.port = 16'(itc_pkg::BasePort + $urandom_range(0, 3));
    k = $urandom_range(0, 99);
    if (k < 35) it.mode = itc_pkg::ModeWrite;
    else if (k < 70) it.mode = itc_pkg::ModeRead;
    else if (k < 93) it.mode = itc_pkg::ModeTick;
    else it.mode = ModeSpare;
    if (it.port == itc_pkg::CtrlPort && it.mode == itc_pkg::ModeWrite
        && $urandom_range(0, 3) == 0)
      it.wdata[5:4] = itc_pkg::OrderLatch;
    if ($urandom_range(0, 19) == 0) it.port = 16'($urandom);
    if ($urandom_range(0, 9) == 0) it.ticks = $urandom;
    if ($urandom_range(0, 9) == 0) it.ticks = $urandom_range(0, 4);
    return it;
  endfunction

  // Receiver with random back-pressure; checks each result transaction.
  always @(negedge clk_i) begin
    m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    timer_result_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[9]};
      if (expected_q.size() == 0) report_mismatch("result with nothing expected");
      else begin
        exp_r = expected_q.pop_front();
        if (got.rdata !== exp_r.rdata)
          report_mismatch($sformatf("read_data %h, expected %h", got.rdata, exp_r.rdata));
        if (got.fired0 !== exp_r.fired0)
          report_mismatch($sformatf("channel0_fired %b, expected %b", got.fired0, exp_r.fired0));
        if (got.flag2 !== exp_r.flag2)
          report_mismatch($sformatf("channel2_flag %b, expected %b", got.flag2, exp_r.flag2));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  stim_row_t table_rows[$];

  task automatic add_row(input timer_item_t it, input logic known, input timer_result_t res);
    stim_row_t r;
    r.item = it; r.known = known; r.res = res;
    table_rows.push_back(r);
  endtask

  initial begin
    for (int i = 0; i < NumChan; i++) begin
      reload_q[i] = '0; count_q[i] = '0; latch_q[i] = '0; held_q[i] = 1'b0;
      order_q[i] = 2'd3; wr_hi_q[i] = 1'b0; rd_hi_q[i] = 1'b0; fired_q[i] = 1'b0;
    end
    // Directed rows: reset values, port edges, all three access orders, latch and wrap.
    add_row(mk(itc_pkg::ModeRead, itc_pkg::BasePort, 8'h00, 32'h0), 1, '0);
    add_row(mk(itc_pkg::ModeRead, itc_pkg::CtrlPort, 8'h00, 32'h0), 1, '0);
    add_row(mk(itc_pkg::ModeRead, 16'h0000, 8'h00, 32'h0), 1, '{8'hFF, 1'b0, 1'b0});
    add_row(mk(itc_pkg::ModeRead, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF), 1, '{8'hFF, 1'b0, 1'b0});
    add_row(mk(itc_pkg::ModeRead, 16'h003F, 8'h00, 32'h0), 1, '{8'hFF, 1'b0, 1'b0});
    add_row(mk(ModeSpare, itc_pkg::BasePort, 8'hFF, 32'hFFFF_FFFF), 1, '0);
    add_row(mk(itc_pkg::ModeWrite, itc_pkg::BasePort, 8'h05, 32'h0), 0, '0);
    add_row(mk(itc_pkg::ModeWrite, itc_pkg::BasePort, 8'h00, 32'h0), 0, '0);
    add_row(mk(itc_pkg::ModeTick, itc_pkg::BasePort, 8'h00, 32'd5), 0, '0);
    add_row(mk(itc_pkg::ModeWrite, itc_pkg::CtrlPort, 8'h00, 32'h0), 0, '0);   // latch channel 0
    add_row(mk(itc_pkg::ModeTick, itc_pkg::BasePort, 8'h00, 32'd2), 0, '0);
    add_row(mk(itc_pkg::ModeRead, itc_pkg::BasePort, 8'h00, 32'h0), 0, '0);
    add_row(mk(itc_pkg::ModeRead, itc_pkg::BasePort, 8'h00, 32'h0), 0, '0);
    add_row(mk(itc_pkg::ModeWrite, itc_pkg::CtrlPort, 8'hD0, 32'h0), 0, '0);   // read-back is ignored
    add_row(mk(itc_pkg::ModeWrite, itc_pkg::CtrlPort, 8'h90, 32'h0), 0, '0);   // channel 2 low only
    add_row(mk(itc_pkg::ModeWrite, 16'h0042, 8'h03, 32'h0), 0, '0);
    add_row(mk(itc_pkg::ModeTick, itc_pkg::BasePort, 8'h00, 32'hFFFF_FFFF), 0, '0);
    add_row(mk(itc_pkg::ModeWrite, itc_pkg::CtrlPort, 8'h60, 32'h0), 0, '0);   // channel 1 high only
    add_row(mk(itc_pkg::ModeWrite, 16'h0041, 8'hFF, 32'h0), 0, '0);
    add_row(mk(itc_pkg::ModeRead, 16'h0041, 8'h00, 32'h0), 0, '0);
    add_row(mk(itc_pkg::ModeTick, itc_pkg::BasePort, 8'h00, 32'h0), 0, '0);
    add_row(mk(itc_pkg::ModeWrite, itc_pkg::CtrlPort, 8'h30, 32'h0), 0, '0);
    add_row(mk(itc_pkg::ModeRead, 16'h0042, 8'h00, 32'h0), 0, '0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (table_rows[i]) send_item(table_rows[i].item, table_rows[i].known, table_rows[i].res);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 28 : 0;
      for (int k = 0; k < 250; k++) begin
        timer_item_t it;
        timer_result_t none;
        none = '0;
        it = random_item();
        if ($urandom_range(0, 7) == 0) begin
          it.mode = itc_pkg::ModeWrite;
          it.port = itc_pkg::CtrlPort;
        end
        send_item(it, 1'b0, none);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
